// ----- src/dvrt_pkg.sv -----
// Shared types, codes and constants of the distance-vector route table.
`default_nettype none
package dvrt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int COST_INFINITY_DEF = 65535;

	localparam logic [4:0] LEN_SELF     = 5'd1;
	localparam logic [4:0] LEN_NEIGHBOR = 5'd2;
	localparam logic [4:0] LEN_MAX      = 5'd31;

	typedef enum logic [2:0] {
		KIND_ADD_NBR  = 3'd0,
		KIND_ADD_SELF = 3'd1,
		KIND_UPDATE   = 3'd2,
		KIND_DEAD     = 3'd3,
		KIND_READ     = 3'd4
	} kind_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  origin_id;
		logic [15:0] link_cost;
		logic [7:0]  dest_id;
		logic [15:0] route_cost;
		logic [7:0]  route_next_hop;
		logic [4:0]  route_path_len;
		logic        last_route;
		logic [3:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        entry_changed;
		logic        packet_changed;
		logic [7:0]  out_dest;
		logic [7:0]  out_next_hop;
		logic [15:0] out_cost;
		logic [4:0]  out_path_len;
		logic [4:0]  route_total;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  dest;
		logic [7:0]  hop;
		logic [15:0] cost;
		logic [4:0]  len;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic read;
		logic commit;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       scan_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- src/dvrt_stream_if.sv -----
// Valid/ready stream channel carrying one payload of type T.
`default_nettype none
interface dvrt_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/distance_vector_route_table.sv -----
// Top level of the distance-vector route table.
// One request is worked at a time. Add-neighbor and add-self requests go
// through a write-back step and read requests through a memory read before
// the response step; a request of an unused kind goes straight to it. An
// update or dead-neighbor request walks the n valid entries through the
// single-read route memory, one entry per cycle; an update stops at the
// first matching entry and then writes back. The response sits in an output
// register; the next request can be accepted once the previous response has
// reached it, and a stalled response holds only the final step of the next.
// The table memory needs no clearing after reset: only data from slots below
// the entry count is used.
`default_nettype none
module distance_vector_route_table
	import dvrt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int COST_INFINITY = COST_INFINITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	dvrt_stream_if.sink     req,
	dvrt_stream_if.source   rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	ctl_cmd_t cmd;
	dp_stat_t stat;
	req_t     req_data;
	rsp_t     rsp_data;

	assign req_data = req.data;
	assign rsp.data = rsp_data;

	dvrt_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req_data.kind),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dvrt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COST_INFINITY (COST_INFINITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_data  (rsp_data)
	);
endmodule
`default_nettype wire

// ----- src/dvrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- src/dvrt_ctl.sv -----
// Controller state machine sequencing load, table scan, write-back and response.
`default_nettype none
module dvrt_ctl
	import dvrt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic [2:0] req_kind,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_COMMIT,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok    = !out_valid_q || rsp_ready;
	assign req_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = out_valid_q;
	assign cmd.load   = (state_q == ST_IDLE) && req_valid;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.read   = (state_q == ST_READ);
	assign cmd.commit = (state_q == ST_COMMIT);
	assign cmd.emit   = (state_q == ST_RESP) && emit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						unique case (req_kind)
							KIND_ADD_NBR, KIND_ADD_SELF: state_q <= ST_COMMIT;
							KIND_UPDATE, KIND_DEAD:      state_q <= ST_SCAN;
							KIND_READ:                   state_q <= ST_READ;
							default:                     state_q <= ST_RESP;
						endcase
					end
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= (stat.kind == KIND_UPDATE) ? ST_COMMIT : ST_RESP;
					end
				end
				ST_READ:   state_q <= ST_RESP;
				ST_COMMIT: state_q <= ST_RESP;
				ST_RESP: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/dvrt_dp.sv -----
// Datapath: request registers, route memory, scan pipeline, write-back and response register.
`default_nettype none
module dvrt_dp
	import dvrt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int COST_INFINITY = COST_INFINITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ctl_cmd_t   cmd,
	output dp_stat_t        stat,
	input  wire req_t       req_data,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	output rsp_t            rsp_data
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int XW = CW + 4;
	localparam logic [15:0] INF = 16'(COST_INFINITY);

	req_t          item_q;
	logic [7:0]    own_id_q;
	logic [CW-1:0] count_q;
	logic          acc_q;
	logic [CW-1:0] iss_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          found_q;
	logic [AW-1:0] hit_idx_q;
	entry_t        hit_ent_q;
	logic          chg_q;
	logic          full_q;
	rsp_t          rsp_q;

	entry_t        rd_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	logic          is_update;
	logic          is_dead;
	logic          is_read;
	logic          more;
	logic          hit_now;
	logic          dead_hit;
	logic          tbl_full;
	logic          idx_ok;
	logic [16:0]   sum;
	logic [15:0]   ncost;
	logic [4:0]    nlen;
	logic [15:0]   nbr_cost;
	logic          replace;
	logic          force_cost;
	logic          append;
	entry_t        app_ent;
	logic          pchg;

	assign is_update = (item_q.kind == KIND_UPDATE);
	assign is_dead   = (item_q.kind == KIND_DEAD);
	assign is_read   = (item_q.kind == KIND_READ);
	assign more      = (iss_q < count_q);
	assign hit_now   = cmd.scan && vld_s1 && is_update && (rd_data.dest == item_q.dest_id);
	assign dead_hit  = cmd.scan && vld_s1 && is_dead && (rd_data.hop == item_q.origin_id);
	assign tbl_full  = (count_q == CW'(TABLE_ENTRIES));
	assign idx_ok    = (XW'(item_q.entry_index) < XW'(count_q))
		&& (XW'(item_q.entry_index) < XW'(TABLE_ENTRIES));

	assign stat.kind      = item_q.kind;
	assign stat.scan_done = hit_now || (!vld_s1 && !more);

	assign sum      = {1'b0, item_q.link_cost} + {1'b0, item_q.route_cost};
	assign ncost    = (sum > {1'b0, INF}) ? INF : sum[15:0];
	assign nlen     = (item_q.route_path_len == LEN_MAX) ? LEN_MAX
		: item_q.route_path_len + 5'd1;
	assign nbr_cost = (item_q.link_cost > INF) ? INF : item_q.link_cost;

	assign replace    = found_q && (ncost < hit_ent_q.cost)
		&& (item_q.route_next_hop != own_id_q);
	assign force_cost = found_q && !replace && (item_q.origin_id == hit_ent_q.hop);
	assign append     = (item_q.kind == KIND_ADD_NBR) || (item_q.kind == KIND_ADD_SELF)
		|| (is_update && !found_q);

	always_comb begin
		unique case (item_q.kind)
			KIND_ADD_NBR:  app_ent = '{item_q.dest_id, item_q.dest_id, nbr_cost, LEN_NEIGHBOR};
			KIND_ADD_SELF: app_ent = '{own_id_q, own_id_q, 16'd0, LEN_SELF};
			default:       app_ent = '{item_q.dest_id, item_q.origin_id, ncost, nlen};
		endcase
	end

	always_comb begin
		rd_en   = (cmd.scan && more) || cmd.read;
		rd_addr = cmd.read ? AW'(item_q.entry_index) : AW'(iss_q);
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data;
		if (dead_hit) begin
			wr_en        = 1'b1;
			wr_data.cost = INF;
		end else if (cmd.commit) begin
			if (append) begin
				wr_en   = !tbl_full;
				wr_addr = AW'(count_q);
				wr_data = app_ent;
			end else begin
				wr_en   = replace || force_cost;
				wr_addr = hit_idx_q;
				wr_data = hit_ent_q;
				wr_data.cost = ncost;
				if (replace) begin
					wr_data.hop = item_q.origin_id;
					wr_data.len = nlen;
				end
			end
		end
	end

	dvrt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign pchg = is_update && (acc_q || chg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= 8'd0;
			count_q  <= '0;
			acc_q    <= 1'b0;
			iss_q    <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			chg_q    <= 1'b0;
			full_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_id_q <= cfg_wdata;
			end
			if (cmd.load) begin
				iss_q   <= '0;
				vld_s1  <= 1'b0;
				found_q <= 1'b0;
				chg_q   <= 1'b0;
				full_q  <= 1'b0;
			end
			if (cmd.scan) begin
				vld_s1 <= more && !hit_now;
				if (more) begin
					iss_q <= iss_q + CW'(1);
				end
				if (hit_now) begin
					found_q <= 1'b1;
				end
				if (dead_hit) begin
					chg_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (append) begin
					if (tbl_full) begin
						full_q <= 1'b1;
					end else begin
						chg_q   <= 1'b1;
						count_q <= count_q + CW'(1);
					end
				end else if (replace || force_cost) begin
					chg_q <= 1'b1;
				end
			end
			if (cmd.emit && is_update) begin
				acc_q <= item_q.last_route ? 1'b0 : pchg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req_data;
		end
		if (cmd.scan) begin
			idx_s1 <= AW'(iss_q);
			if (hit_now) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= rd_data;
			end
		end
		if (cmd.emit) begin
			rsp_q.entry_changed  <= chg_q;
			rsp_q.packet_changed <= pchg;
			rsp_q.route_total    <= 5'(count_q);
			if (full_q) begin
				rsp_q.status <= STATUS_FULL;
			end else if (is_read && !idx_ok) begin
				rsp_q.status <= STATUS_BAD_INDEX;
			end else begin
				rsp_q.status <= STATUS_OK;
			end
			if (is_read && idx_ok) begin
				rsp_q.out_dest     <= rd_data.dest;
				rsp_q.out_next_hop <= rd_data.hop;
				rsp_q.out_cost     <= rd_data.cost;
				rsp_q.out_path_len <= rd_data.len;
			end else begin
				rsp_q.out_dest     <= 8'd0;
				rsp_q.out_next_hop <= 8'd0;
				rsp_q.out_cost     <= 16'd0;
				rsp_q.out_path_len <= 5'd0;
			end
		end
	end

	assign rsp_data = rsp_q;
endmodule
`default_nettype wire

// ----- src/dvrt_checker.sv -----
// Port-level assertions for the route table and the bind that attaches them.
`default_nettype none
module dvrt_checker
	import dvrt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_FULL)
			|| (rsp_data.status == STATUS_BAD_INDEX))
		else $error("undefined status code");

	a_fail_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status != STATUS_OK) |-> !rsp_data.entry_changed
			&& (rsp_data.out_cost == 16'd0) && (rsp_data.out_path_len == 5'd0))
		else $error("failed request reports a change or entry data");
endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the distance-vector route table: directed and random requests.
`timescale 1ns / 100ps
module tb;
	import dvrt_pkg::*;

	localparam int          CYCLE_LIMIT     = 1000000;
	localparam int          RANDOM_PHASES   = 8;
	localparam int          ITEMS_PER_PHASE = 225;
	localparam int          DRAIN_CYCLES    = 40;
	localparam logic [15:0] COST_INF        = 16'(COST_INFINITY_DEF);
	localparam logic [2:0]  KIND_UNUSED_LO  = 3'd5;
	localparam logic [2:0]  KIND_UNUSED_HI  = 3'd7;

	class route_table_check;
		logic [7:0]  dest_tab [TABLE_ENTRIES_DEF];
		logic [7:0]  hop_tab  [TABLE_ENTRIES_DEF];
		logic [15:0] cost_tab [TABLE_ENTRIES_DEF];
		logic [4:0]  len_tab  [TABLE_ENTRIES_DEF];
		int          route_count;
		logic        packet_acc;
		logic [7:0]  router_id;
		rsp_t        awaited[$];
		int          errors;
		int          checked;
		int          n_replaced;
		int          n_refreshed;
		int          n_dropped;
		int          n_bad_read;

		function new();
			route_count = 0;
			packet_acc = 1'b0;
			router_id = 8'h00;
			errors = 0;
			checked = 0;
			n_replaced = 0;
			n_refreshed = 0;
			n_dropped = 0;
			n_bad_read = 0;
		endfunction

		function void set_router_id(logic [7:0] id);
			router_id = id;
		endfunction

		function bit append_route(logic [7:0] d, logic [7:0] h, logic [15:0] c,
			logic [4:0] len);
			if (route_count >= TABLE_ENTRIES_DEF) begin
				n_dropped++;
				return 1'b0;
			end
			dest_tab[route_count] = d;
			hop_tab[route_count]  = h;
			cost_tab[route_count] = c;
			len_tab[route_count]  = len;
			route_count++;
			return 1'b1;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			logic [16:0] sum;
			logic [15:0] ncost;
			logic [4:0]  nlen;
			bit          found;
			e = '0;
			found = 1'b0;
			case (r.kind)
				KIND_ADD_NBR: begin
					if (append_route(r.dest_id, r.dest_id, r.link_cost, LEN_NEIGHBOR))
						e.entry_changed = 1'b1;
					else
						e.status = STATUS_FULL;
				end
				KIND_ADD_SELF: begin
					if (append_route(router_id, router_id, 16'd0, LEN_SELF))
						e.entry_changed = 1'b1;
					else
						e.status = STATUS_FULL;
				end
				KIND_UPDATE: begin
					sum = {1'b0, r.link_cost} + {1'b0, r.route_cost};
					ncost = (sum > {1'b0, COST_INF}) ? COST_INF : sum[15:0];
					nlen = (r.route_path_len == LEN_MAX) ? LEN_MAX : r.route_path_len + 5'd1;
					for (int i = 0; i < route_count && !found; i++) begin
						if (dest_tab[i] == r.dest_id) begin
							found = 1'b1;
							if (ncost < cost_tab[i] && r.route_next_hop != router_id) begin
								hop_tab[i]  = r.origin_id;
								cost_tab[i] = ncost;
								len_tab[i]  = nlen;
								e.entry_changed = 1'b1;
								n_replaced++;
							end else if (r.origin_id == hop_tab[i]) begin
								cost_tab[i] = ncost;
								e.entry_changed = 1'b1;
								n_refreshed++;
							end
						end
					end
					if (!found) begin
						if (append_route(r.dest_id, r.origin_id, ncost, nlen))
							e.entry_changed = 1'b1;
						else
							e.status = STATUS_FULL;
					end
					e.packet_changed = packet_acc | e.entry_changed;
					packet_acc = r.last_route ? 1'b0 : e.packet_changed;
				end
				KIND_DEAD: begin
					for (int i = 0; i < route_count; i++) begin
						if (hop_tab[i] == r.origin_id) begin
							cost_tab[i] = COST_INF;
							e.entry_changed = 1'b1;
						end
					end
				end
				KIND_READ: begin
					if (r.entry_index < route_count) begin
						e.out_dest     = dest_tab[r.entry_index];
						e.out_next_hop = hop_tab[r.entry_index];
						e.out_cost     = cost_tab[r.entry_index];
						e.out_path_len = len_tab[r.entry_index];
					end else begin
						e.status = STATUS_BAD_INDEX;
						n_bad_read++;
					end
				end
				default: begin
				end
			endcase
			e.route_total = route_count[4:0];
			awaited.push_back(e);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("status", 16'(want.status), 16'(got.status));
			compare_field("entry_changed", 16'(want.entry_changed), 16'(got.entry_changed));
			compare_field("packet_changed", 16'(want.packet_changed), 16'(got.packet_changed));
			compare_field("out_dest", 16'(want.out_dest), 16'(got.out_dest));
			compare_field("out_next_hop", 16'(want.out_next_hop), 16'(got.out_next_hop));
			compare_field("out_cost", want.out_cost, got.out_cost);
			compare_field("out_path_len", 16'(want.out_path_len), 16'(got.out_path_len));
			compare_field("route_total", 16'(want.route_total), 16'(got.route_total));
			checked++;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         cycle_count = 0;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         requests_sent;
	int         id_settings;

	route_table_check sb = new();

	dvrt_stream_if #(.T(req_t)) req_ch ();
	dvrt_stream_if #(.T(rsp_t)) rsp_ch ();

	distance_vector_route_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.data);
	end

	task automatic set_pacing(int mode);
		case (mode)
			1: begin
				send_idle_pct = 66;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 66;
			end
			3: begin
				send_idle_pct = 8;
				recv_stall_pct = 8;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic send_request(req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(r);
		requests_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_router_id(logic [7:0] id);
		cfg_we <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_router_id(id);
		id_settings++;
	endtask

	function automatic req_t mk(logic [2:0] k, logic [7:0] s, logic [15:0] lc,
		logic [7:0] d, logic [15:0] rc, logic [7:0] rh, logic [4:0] len, logic last,
		logic [3:0] idx);
		req_t r;
		r.kind = k;
		r.origin_id = s;
		r.link_cost = lc;
		r.dest_id = d;
		r.route_cost = rc;
		r.route_next_hop = rh;
		r.route_path_len = len;
		r.last_route = last;
		r.entry_index = idx;
		return r;
	endfunction

	function automatic req_t rand_req(logic [2:0] k);
		return mk(k, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
			1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
	endfunction

	function automatic logic [15:0] pick_cost();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom_range(0, 15));
			4, 5, 6:    return 16'($urandom_range(0, 1023));
			7:          return 16'($urandom_range(0, 65535));
			default:    return 16'($urandom_range(65000, 65535));
		endcase
	endfunction

	function automatic logic [7:0] pick_dest();
		if (sb.route_count > 0 && $urandom_range(0, 3) != 0)
			return sb.dest_tab[$urandom_range(0, sb.route_count - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_sender();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if (sb.route_count > 0)
					return sb.hop_tab[$urandom_range(0, sb.route_count - 1)];
				return 8'($urandom_range(0, 7));
			end
			5, 6:    return 8'($urandom_range(0, 7));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one update packet from a single neighbor; a few are malformed
	task automatic run_packet();
		logic [7:0] snd;
		logic [15:0] lc;
		int n;
		bit broken;
		req_t r;
		snd = pick_sender();
		lc = pick_cost();
		n = $urandom_range(1, 6);
		broken = ($urandom_range(0, 9) == 0);
		for (int k = 0; k < n; k++) begin
			r = rand_req(KIND_UPDATE);
			r.origin_id = (broken && $urandom_range(0, 1)) ? pick_sender() : snd;
			r.link_cost = (broken && $urandom_range(0, 1)) ? pick_cost() : lc;
			r.dest_id = pick_dest();
			r.route_cost = pick_cost();
			if ($urandom_range(0, 4) == 0)
				r.route_next_hop = sb.router_id;
			if ($urandom_range(0, 3) != 0)
				r.route_path_len = 5'($urandom_range(1, 16));
			r.last_route = broken ? r.last_route : (k == n - 1);
			send_request(r);
		end
	endtask

	task automatic run_single();
		req_t r;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: begin
				r = rand_req(KIND_DEAD);
				r.origin_id = pick_sender();
			end
			6, 7, 8, 9, 10, 11, 12: r = rand_req(KIND_READ);
			13, 14: begin
				r = rand_req(KIND_ADD_NBR);
				r.link_cost = pick_cost();
			end
			15: r = rand_req(KIND_ADD_SELF);
			16: r = rand_req(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)));
			default: begin
				r = rand_req(KIND_UPDATE);
				r.dest_id = pick_dest();
				r.origin_id = pick_sender();
				r.route_cost = pick_cost();
			end
		endcase
		send_request(r);
	endtask

	task automatic run_directed();
		send_request(mk(KIND_READ, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_DEAD, 8'h05, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_UNUSED_LO, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31, 1'b1,
			4'd15));
		send_request(mk(KIND_UNUSED_HI, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31, 1'b1,
			4'd15));
		send_request(mk(KIND_ADD_NBR, 8'h00, 16'h0001, 8'h01, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_ADD_NBR, 8'h00, 16'hFFFF, 8'hFF, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_ADD_SELF, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		// misses: plain append, then saturated cost and path length
		send_request(mk(KIND_UPDATE, 8'h01, 16'd1, 8'h20, 16'd10, 8'h33, 5'd1, 1'b0, 4'd0));
		send_request(mk(KIND_UPDATE, 8'hFF, 16'hFFFF, 8'h21, 16'hFFFF, 8'h00, 5'd31, 1'b0, 4'd0));
		// cheaper route replaces, packet ends
		send_request(mk(KIND_UPDATE, 8'h01, 16'd0, 8'hFF, 16'd0, 8'h01, 5'd0, 1'b1, 4'd0));
		// no gain from a foreign sender
		send_request(mk(KIND_UPDATE, 8'h02, 16'd5, 8'h20, 16'd100, 8'h02, 5'd3, 1'b1, 4'd0));
		// current next hop forces a worse cost, then the same cost again
		send_request(mk(KIND_UPDATE, 8'h01, 16'd5, 8'h20, 16'd100, 8'h02, 5'd3, 1'b0, 4'd0));
		send_request(mk(KIND_UPDATE, 8'h03, 16'd0, 8'h21, 16'd0, sb.router_id, 5'd2, 1'b0, 4'd0));
		send_request(mk(KIND_UPDATE, 8'h01, 16'd5, 8'h20, 16'd100, 8'h02, 5'd3, 1'b1, 4'd0));
		send_request(mk(KIND_DEAD, 8'h01, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_READ, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd1));
		send_request(mk(KIND_READ, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd4));
		send_request(mk(KIND_READ, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd15));
		// fill the table, first with a duplicate destination
		while (sb.route_count < TABLE_ENTRIES_DEF)
			send_request(mk(KIND_ADD_NBR, 8'h00, 16'($urandom_range(0, 65535)),
				(sb.route_count == 5) ? 8'h20 : 8'h40 + sb.route_count[7:0], 16'h0000, 8'h00,
				5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_ADD_SELF, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd0));
		send_request(mk(KIND_UPDATE, 8'h07, 16'd1, 8'hEE, 16'd1, 8'h07, 5'd4, 1'b1, 4'd0));
		send_request(mk(KIND_READ, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 5'd0, 1'b0, 4'd15));
	endtask

	initial begin
		int phase_end;
		logic [7:0] id;
		requests_sent = 0;
		id_settings = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		set_pacing(0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_router_id(8'h11);
		run_directed();
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       id = 8'hFF;
				1:       id = 8'h00;
				2:       id = 8'h01;
				default: id = 8'($urandom_range(0, 255));
			endcase
			write_router_id(id);
			set_pacing(p % 4);
			phase_end = requests_sent + ITEMS_PER_PHASE;
			while (requests_sent < phase_end) begin
				if ($urandom_range(0, 99) < 60)
					run_packet();
				else
					run_single();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.awaited.size() != 0)
			$display("%0t: %0d responses never arrived", $time, sb.awaited.size());
		$display("Checked %0d responses to %0d requests under %0d router ids and four pacing modes.",
			sb.checked, requests_sent, id_settings);
		$display("Saw %0d replacements, %0d next-hop refreshes, %0d dropped appends, %0d bad reads.",
			sb.n_replaced, sb.n_refreshed, sb.n_dropped, sb.n_bad_read);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
src/dvrt_pkg.sv
src/dvrt_stream_if.sv
src/dvrt_ram.sv
src/dvrt_ctl.sv
src/dvrt_dp.sv
src/distance_vector_route_table.sv
src/dvrt_checker.sv
tb/sv/tb.sv
